[hw/rtl/saa_pkg.sv]
// ----------------------------------------------------------------------------
// saa_pkg: shared types and constants of the stack arena allocator
// Request and response payloads, operation and status codes, fixed sizing.
// ----------------------------------------------------------------------------
package saa_pkg;

	// Default sizing, handed to the top-level parameters
	localparam int unsigned MAX_PAGES_DEF   = 64;
	localparam int unsigned LARGE_MAX_DEF   = 64;
	localparam int unsigned STACK_DEPTH_DEF = 32;

	// Fixed geometry of pages and frame records (word size is a power of two)
	localparam int unsigned WORD_BYTES   = 8;
	localparam int unsigned HEADER_BYTES = 16;
	localparam int unsigned FRAME_BYTES  = 32;

	localparam int unsigned PAGE_W = 17;
	localparam logic [PAGE_W-1:0] PG_BYTES_RESET = PAGE_W'(4096);
	localparam logic [PAGE_W-1:0] PG_BYTES_MAX   = PAGE_W'(65536);
	localparam logic [PAGE_W-1:0] HDR_ROUND =
		PAGE_W'(((HEADER_BYTES + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES);
	localparam logic [PAGE_W:0] WORD_MASK = (PAGE_W + 1)'(WORD_BYTES - 1);

	typedef enum logic [1:0] {
		KIND_ALLOC_ALIGNED   = 2'd0,
		KIND_ALLOC_UNALIGNED = 2'd1,
		KIND_PUSH            = 2'd2,
		KIND_POP             = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_SPACE   = 2'd1,
		ST_BAD_POS    = 2'd2,
		ST_STACK_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PL_PAGE  = 2'd0,
		PL_LARGE = 2'd1,
		PL_NONE  = 2'd2
	} placement_t;

	typedef struct packed {
		kind_t       kind;
		logic [23:0] size;
		logic [5:0]  stack_pos;
	} saa_req_t;

	typedef struct packed {
		status_t     status;
		placement_t  placement;
		logic [5:0]  page_index;
		logic [15:0] offset;
		logic [5:0]  large_index;
		logic [5:0]  depth;
	} saa_rsp_t;

	// Round a page offset up to the next word boundary
	function automatic logic [PAGE_W:0] round_word(input logic [PAGE_W-1:0] v);
		logic [PAGE_W:0] sum;
		sum = (PAGE_W + 1)'(v) + WORD_MASK;
		return sum & ~WORD_MASK;
	endfunction

endpackage

[hw/rtl/saa_frame_mem.sv]
// ----------------------------------------------------------------------------
// saa_frame_mem: frame record memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module saa_frame_mem #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5,
	parameter int unsigned W     = 31
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	// Write saved frame
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read and hold until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/saa_core.sv]
// ----------------------------------------------------------------------------
// saa_core: allocator state and update logic
// Holds page count, cursor, oversized count, frame depth and teardown flag;
// decides placement of one request and commits the new state.
// ----------------------------------------------------------------------------
module saa_core import saa_pkg::*; #(
	parameter int unsigned MAX_PAGES   = MAX_PAGES_DEF,
	parameter int unsigned LARGE_MAX   = LARGE_MAX_DEF,
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
	localparam int unsigned OPW = $clog2(MAX_PAGES + 1),
	localparam int unsigned LW  = $clog2(LARGE_MAX + 1),
	localparam int unsigned DW  = $clog2(STACK_DEPTH + 1),
	localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
	localparam int unsigned FW  = OPW + PAGE_W + LW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PAGE_W-1:0] pg_bytes,
	input  saa_req_t          op,
	input  logic              commit,
	input  logic [FW-1:0]     frame_rd,
	output saa_rsp_t          result,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [FW-1:0]     mem_wdata
);

	localparam int unsigned CW = (DW > 6) ? DW : 6;

	logic [OPW-1:0]    open_q, open_d;
	logic [PAGE_W-1:0] cursor_q, cursor_d;
	logic [LW-1:0]     large_q, large_d;
	logic [DW-1:0]     depth_q, depth_d;
	logic              torn_q, torn_d;

	logic [PAGE_W-1:0] ps;
	logic              align;
	logic [23:0]       sz;
	logic [PAGE_W:0]   at;
	logic [24:0]       sum_cur;
	logic              fit_cur, fit_new, fit_large;

	logic              a_ok;
	placement_t        a_place;
	logic [5:0]        a_page;
	logic [15:0]       a_off;
	logic [5:0]        a_large_idx;
	logic [OPW-1:0]    a_open;
	logic [PAGE_W-1:0] a_cursor;
	logic [LW-1:0]     a_large;

	logic [CW-1:0]     pos_c, dep_c;
	logic              push_ok;

	// Effective page size and placement checks
	always_comb begin
		ps      = (pg_bytes > PG_BYTES_MAX) ? PG_BYTES_MAX : pg_bytes;
		align   = (op.kind != KIND_ALLOC_UNALIGNED);
		sz      = (op.kind == KIND_PUSH) ? 24'(FRAME_BYTES) : op.size;
		at      = align ? round_word(cursor_q) : (PAGE_W + 1)'(cursor_q);
		sum_cur = 25'(at) + 25'(sz);
		fit_cur = !torn_q && (sum_cur <= 25'(ps));
		fit_new = !torn_q && (ps >= HDR_ROUND) && (25'(sz) <= 25'(ps - HDR_ROUND))
			&& (open_q < OPW'(MAX_PAGES));
		fit_large = (large_q < LW'(LARGE_MAX));
	end

	// Place one allocation: current page, fresh page, oversized list
	always_comb begin
		a_ok        = 1'b1;
		a_place     = PL_NONE;
		a_page      = '0;
		a_off       = '0;
		a_large_idx = '0;
		a_open      = open_q;
		a_cursor    = cursor_q;
		a_large     = large_q;
		priority if (fit_cur) begin
			a_place  = PL_PAGE;
			a_page   = 6'(open_q - OPW'(1));
			a_off    = at[15:0];
			a_cursor = sum_cur[PAGE_W-1:0];
		end else if (fit_new) begin
			a_place  = PL_PAGE;
			a_page   = 6'(open_q);
			a_off    = HDR_ROUND[15:0];
			a_open   = open_q + OPW'(1);
			a_cursor = HDR_ROUND + sz[PAGE_W-1:0];
		end else if (fit_large) begin
			a_place     = PL_LARGE;
			a_large_idx = 6'(large_q);
			a_large     = large_q + LW'(1);
		end else begin
			a_ok = 1'b0;
		end
	end

	// Resolve the operation and the next state
	always_comb begin
		pos_c   = CW'(op.stack_pos);
		dep_c   = CW'(depth_q);
		push_ok = 1'b0;
		open_d   = open_q;
		cursor_d = cursor_q;
		large_d  = large_q;
		depth_d  = depth_q;
		torn_d   = torn_q;
		result.status      = ST_OK;
		result.placement   = PL_NONE;
		result.page_index  = '0;
		result.offset      = '0;
		result.large_index = '0;
		unique case (op.kind)
			KIND_ALLOC_ALIGNED, KIND_ALLOC_UNALIGNED: begin
				result.status      = a_ok ? ST_OK : ST_NO_SPACE;
				result.placement   = a_place;
				result.page_index  = a_page;
				result.offset      = a_off;
				result.large_index = a_large_idx;
				open_d   = a_open;
				cursor_d = a_cursor;
				large_d  = a_large;
			end
			KIND_PUSH: begin
				if (depth_q >= DW'(STACK_DEPTH)) begin
					result.status = ST_STACK_FULL;
				end else begin
					result.status      = a_ok ? ST_OK : ST_NO_SPACE;
					result.placement   = a_place;
					result.page_index  = a_page;
					result.offset      = a_off;
					result.large_index = a_large_idx;
					open_d   = a_open;
					cursor_d = a_cursor;
					large_d  = a_large;
					push_ok  = a_ok;
					if (a_ok) begin
						depth_d = depth_q + DW'(1);
					end
				end
			end
			KIND_POP: begin
				priority if (pos_c > dep_c) begin
					result.status = ST_BAD_POS;
				end else if (pos_c == '0) begin
					open_d   = '0;
					cursor_d = '0;
					large_d  = '0;
					depth_d  = '0;
					torn_d   = 1'b1;
				end else begin
					open_d   = frame_rd[FW-1 -: OPW];
					cursor_d = frame_rd[LW +: PAGE_W];
					large_d  = frame_rd[LW-1:0];
					depth_d  = DW'(op.stack_pos);
				end
			end
			default: begin
				result.status = ST_OK;
			end
		endcase
		result.depth = 6'(depth_d);
	end

	// Save the frame record for a successful push
	assign mem_we    = commit && push_ok;
	assign mem_waddr = AW'(depth_q);
	assign mem_wdata = {a_open, a_cursor, a_large};

	// Commit the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= OPW'(1);
			cursor_q <= HDR_ROUND;
			large_q  <= '0;
			depth_q  <= '0;
			torn_q   <= 1'b0;
		end else if (commit) begin
			open_q   <= open_d;
			cursor_q <= cursor_d;
			large_q  <= large_d;
			depth_q  <= depth_d;
			torn_q   <= torn_d;
		end
	end

endmodule

[hw/rtl/stack_arena_allocator.sv]
// ----------------------------------------------------------------------------
// stack_arena_allocator: bump allocator over pages with a mark/release stack
// A request transfer loads the request stage and, for a pop, reads the frame
// record memory at the same edge. Once the response register is empty or its
// response is being taken, the core decides the placement, writes back the
// allocator state and loads the response register at the same edge. The
// request port is not ready while a request sits in the stage, so the block
// takes no new request until the staged one has been committed. A response
// waiting in the output register holds the staged request, and that holds
// the request port: at most one further request is taken behind a stalled
// response. The user must write the page size register through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module stack_arena_allocator import saa_pkg::*; #(
	parameter int unsigned MAX_PAGES   = MAX_PAGES_DEF,
	parameter int unsigned LARGE_MAX   = LARGE_MAX_DEF,
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [PAGE_W-1:0] cfg_wdata,
	input  logic              req_valid,
	output logic              req_ready,
	input  saa_req_t          req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output saa_rsp_t          rsp
);

	localparam int unsigned OPW = $clog2(MAX_PAGES + 1);
	localparam int unsigned LW  = $clog2(LARGE_MAX + 1);
	localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned FW  = OPW + PAGE_W + LW;

	logic [PAGE_W-1:0] pg_bytes_q;
	logic              valid_s1;
	saa_req_t          req_s1;
	logic              rsp_valid_q;
	saa_rsp_t          rsp_q;

	logic              accept;
	logic              out_free;
	logic              commit;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [FW-1:0]     frame_rd;
	saa_rsp_t          result;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [FW-1:0]     mem_wdata;

	// Page size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_bytes_q <= PG_BYTES_RESET;
		end else if (cfg_we) begin
			pg_bytes_q <= cfg_wdata;
		end
	end

	// Request transfer and frame lookup for a pop
	assign req_ready = !valid_s1;
	assign accept    = req_valid && req_ready;
	assign rd_en     = accept && (req.kind == KIND_POP);
	assign rd_addr   = AW'(req.stack_pos - 6'd1);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign commit    = valid_s1 && out_free;

	// Hold the request from its transfer until it commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	saa_frame_mem #(
		.DEPTH(STACK_DEPTH),
		.AW   (AW),
		.W    (FW)
	) u_frame_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(frame_rd)
	);

	saa_core #(
		.MAX_PAGES  (MAX_PAGES),
		.LARGE_MAX  (LARGE_MAX),
		.STACK_DEPTH(STACK_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.pg_bytes (pg_bytes_q),
		.op       (req_s1),
		.commit   (commit),
		.frame_rd (frame_rd),
		.result   (result),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata)
	);

	// Response register: load on commit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[dv/stack_arena_allocator_tb.sv]
// ----------------------------------------------------------------------------
// stack_arena_allocator_tb: self-checking bench for the stack arena allocator
// A clocked driver feeds requests from a backlog queue and a clocked monitor
// predicts the response of every accepted request, then compares each
// response field by field in order. Phases cover page sizes from the
// degenerate to the largest, with different sender and receiver pacing, one
// long response hold-off, pool and stack exhaustion, and a final teardown.
// ----------------------------------------------------------------------------
module stack_arena_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import saa_pkg::*;

	localparam int unsigned HDR = HDR_ROUND;
	localparam int unsigned TIMEOUT_NS = 4_000_000;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} pace_t;

	// Saved allocator position of one frame
	typedef struct packed {
		logic [6:0]  pages;
		logic [16:0] cur;
		logic [6:0]  oversz;
	} frame_mark_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [PAGE_W-1:0] cfg_wdata = '0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	saa_req_t          req       = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	saa_rsp_t          rsp;

	pace_t pace      = IDLE_NONE;
	int    hold_left = 0;
	bit    hold_go   = 1'b0;
	bit    hold_done = 1'b0;

	saa_req_t request_backlog[$];
	saa_rsp_t expected_grants[$];

	int mismatch_count = 0;
	int grant_count    = 0;
	int phase_count    = 0;
	int placed_seen[3] = '{0, 0, 0};
	int status_seen[4] = '{0, 0, 0, 0};

	// Shadow of the allocator state
	logic [16:0] arena_pg_bytes  = PG_BYTES_RESET;
	logic [6:0]  arena_pages     = 7'd1;
	logic [16:0] arena_cursor    = 17'(HDR);
	logic [6:0]  arena_large     = '0;
	logic [5:0]  arena_depth     = '0;
	bit          arena_torn      = 1'b0;
	frame_mark_t arena_frames[STACK_DEPTH_DEF];

	stack_arena_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned word_up(input int unsigned v);
		return (v + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;
	endfunction

	// Place a block: current page, then a fresh page, then the oversized list
	function automatic status_t place_block(input int unsigned sz, input bit align,
			inout saa_rsp_t g);
		int unsigned ps;
		int unsigned at;
		ps = (arena_pg_bytes > 65536) ? 65536 : arena_pg_bytes;
		if (!arena_torn) begin
			at = align ? word_up(arena_cursor) : arena_cursor;
			if (at + sz <= ps) begin
				arena_cursor = 17'(at + sz);
				g.placement  = PL_PAGE;
				g.page_index = 6'(arena_pages - 1);
				g.offset     = 16'(at);
				return ST_OK;
			end
			if (ps >= HDR && sz <= ps - HDR && arena_pages < MAX_PAGES_DEF) begin
				arena_pages++;
				arena_cursor = 17'(HDR + sz);
				g.placement  = PL_PAGE;
				g.page_index = 6'(arena_pages - 1);
				g.offset     = 16'(HDR);
				return ST_OK;
			end
		end
		if (arena_large < LARGE_MAX_DEF) begin
			g.placement   = PL_LARGE;
			g.large_index = 6'(arena_large);
			arena_large++;
			return ST_OK;
		end
		return ST_NO_SPACE;
	endfunction

	// Advance the shadow state by one request and build its response
	function automatic void arena_step(input saa_req_t q, output saa_rsp_t g);
		status_t     st;
		frame_mark_t mark;
		g = '0;
		g.placement = PL_NONE;
		case (q.kind)
			KIND_ALLOC_ALIGNED, KIND_ALLOC_UNALIGNED: begin
				st = place_block(q.size, q.kind == KIND_ALLOC_ALIGNED, g);
				g.status = st;
			end
			KIND_PUSH: begin
				if (arena_depth >= STACK_DEPTH_DEF) begin
					g.status = ST_STACK_FULL;
				end else begin
					st = place_block(FRAME_BYTES, 1'b1, g);
					g.status = st;
					if (st == ST_OK) begin
						arena_frames[arena_depth] = '{arena_pages, arena_cursor, arena_large};
						arena_depth++;
					end
				end
			end
			default: begin
				if (q.stack_pos > arena_depth) begin
					g.status = ST_BAD_POS;
				end else if (q.stack_pos == 0) begin
					// tear down: no pages left, everything goes oversized
					arena_pages  = '0;
					arena_cursor = '0;
					arena_large  = '0;
					arena_depth  = '0;
					arena_torn   = 1'b1;
				end else begin
					mark         = arena_frames[q.stack_pos - 1];
					arena_pages  = mark.pages;
					arena_cursor = mark.cur;
					arena_large  = mark.oversz;
					arena_depth  = q.stack_pos;
				end
			end
		endcase
		g.depth = arena_depth;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("ERROR %0t ns: %s", $time, msg);
	endtask

	// Compare one response with the oldest expected grant
	task automatic check_grant(input saa_rsp_t got);
		saa_rsp_t want;
		grant_count++;
		if (expected_grants.size() == 0) begin
			report_mismatch($sformatf("response %0d with nothing outstanding: %h",
				grant_count, got));
		end else begin
			want = expected_grants.pop_front();
			placed_seen[want.placement]++;
			status_seen[want.status]++;
			if (got.status !== want.status)
				report_mismatch($sformatf("response %0d status %0d, want %0d",
					grant_count, got.status, want.status));
			if (got.placement !== want.placement)
				report_mismatch($sformatf("response %0d placement %0d, want %0d",
					grant_count, got.placement, want.placement));
			if (got.page_index !== want.page_index)
				report_mismatch($sformatf("response %0d page_index %0d, want %0d",
					grant_count, got.page_index, want.page_index));
			if (got.offset !== want.offset)
				report_mismatch($sformatf("response %0d offset %0d, want %0d",
					grant_count, got.offset, want.offset));
			if (got.large_index !== want.large_index)
				report_mismatch($sformatf("response %0d large_index %0d, want %0d",
					grant_count, got.large_index, want.large_index));
			if (got.depth !== want.depth)
				report_mismatch($sformatf("response %0d depth %0d, want %0d",
					grant_count, got.depth, want.depth));
		end
	endtask

	function automatic bit sender_rests();
		case (pace)
			IDLE_SEND: return $urandom_range(0, 99) < 78;
			IDLE_BOTH: return $urandom_range(0, 99) < 18;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (pace)
			IDLE_RECV: return $urandom_range(0, 99) < 78;
			IDLE_BOTH: return $urandom_range(0, 99) < 18;
			default:   return 1'b0;
		endcase
	endfunction

	// Drive requests: advance to the next one after each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_ready) begin
			if (request_backlog.size() != 0 && !sender_rests()) begin
				req       <= request_backlog.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Start the response hold-off once, then count it down
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Pace the response side; drop ready during a hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= !receiver_stalls();
		end
	end

	// Predict on each request transfer, check on each response transfer
	always @(posedge clk) begin : monitor
		saa_rsp_t grant;
		if (arst_n) begin
			if (cfg_we)
				arena_pg_bytes = cfg_wdata;
			if (req_valid && req_ready) begin
				arena_step(req, grant);
				expected_grants.push_back(grant);
			end
			if (rsp_valid && rsp_ready)
				check_grant(rsp);
		end
	end

	task automatic add_request(input kind_t k, input int unsigned sz, input int unsigned pos);
		saa_req_t q;
		q.kind      = k;
		q.size      = 24'(sz);
		q.stack_pos = 6'(pos);
		request_backlog.push_back(q);
	endtask

	// Random request, mostly allocations with sizes around the page geometry
	function automatic saa_req_t make_request(input int unsigned ps, input bit allow_teardown);
		saa_req_t    q;
		int unsigned roll;
		int unsigned eff;
		int unsigned room;
		q.size      = 24'($urandom);
		q.stack_pos = 6'($urandom);
		q.kind      = kind_t'($urandom_range(0, 1));
		eff  = (ps > 65536) ? 65536 : ps;
		room = (eff > HDR) ? eff - HDR : 0;
		roll = $urandom_range(0, 99);
		if (roll < 68) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: q.size = 24'($urandom_range(0, 64));
				4, 5:       q.size = 24'($urandom_range(0, eff));
				6:          q.size = (room < 2) ? 24'($urandom_range(0, 4))
					: 24'(room - 2 + $urandom_range(0, 4));
				7, 8:       q.size = 24'($urandom_range(0, 65536));
				default:    q.size = 24'($urandom);
			endcase
		end else if (roll < 83) begin
			q.kind = KIND_PUSH;
		end else if (roll < 95) begin
			q.kind = KIND_POP;
			roll = $urandom_range(0, 99);
			if (roll < 60)
				q.stack_pos = 6'($urandom_range(1, 3));
			else if (roll < 85)
				q.stack_pos = 6'($urandom_range(1, 33));
			else
				q.stack_pos = 6'($urandom_range(1, 63));
			if (allow_teardown && $urandom_range(0, 9) == 0)
				q.stack_pos = '0;
		end else begin
			q.kind = kind_t'($urandom_range(0, 3));
		end
		// keep the teardown out of phases that need live pages
		if (q.kind == KIND_POP && q.stack_pos == 0 && !allow_teardown)
			q.stack_pos = 6'd1;
		return q;
	endfunction

	task automatic add_random(input int unsigned ps, input int n, input bit allow_teardown);
		repeat (n) request_backlog.push_back(make_request(ps, allow_teardown));
	endtask

	// Hold until every request has been sent and every response checked
	task automatic drain();
		while (request_backlog.size() != 0 || expected_grants.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write the page size while idle and set the pacing of the next phase
	task automatic start_phase(input logic [PAGE_W-1:0] ps, input pace_t p);
		drain();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= ps;
		pace      <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		phase_count++;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: base frame, alignment, page edges, oversized, bad positions
		start_phase(PG_BYTES_RESET, IDLE_NONE);
		add_request(KIND_PUSH, 24'hFFFFFF, 63);
		add_request(KIND_ALLOC_ALIGNED, 0, 63);
		add_request(KIND_ALLOC_UNALIGNED, 1, 0);
		add_request(KIND_ALLOC_ALIGNED, 1, 0);
		add_request(KIND_ALLOC_UNALIGNED, 3, 0);
		add_request(KIND_PUSH, 0, 0);
		add_request(KIND_ALLOC_ALIGNED, 4000, 0);
		add_request(KIND_ALLOC_UNALIGNED, 0, 0);
		add_request(KIND_ALLOC_ALIGNED, 4080, 0);
		add_request(KIND_ALLOC_ALIGNED, 4081, 0);
		add_request(KIND_ALLOC_UNALIGNED, 24'hFFFFFF, 0);
		add_request(KIND_POP, 0, 3);
		add_request(KIND_POP, 24'hFFFFFF, 63);
		add_request(KIND_POP, 0, 2);
		add_request(KIND_ALLOC_ALIGNED, 8, 0);
		add_request(KIND_POP, 0, 1);
		add_request(KIND_PUSH, 0, 0);
		add_request(KIND_POP, 0, 2);
		add_request(KIND_ALLOC_UNALIGNED, 4048, 0);
		add_request(KIND_POP, 0, 1);

		// Full-rate traffic with a long response hold-off to back up the input
		start_phase(17'd1024, IDLE_NONE);
		add_random(1024, 350, 1'b0);
		@(posedge clk);
		hold_go <= 1'b1;

		// Page of 64 bytes: exhaust the pool, the oversized list and the stack
		start_phase(17'd64, IDLE_SEND);
		add_request(KIND_POP, 0, 1);
		repeat (130) add_request(KIND_ALLOC_ALIGNED, 40, 0);
		add_request(KIND_PUSH, 0, 0);
		add_request(KIND_POP, 0, 1);
		repeat (32) add_request(KIND_PUSH, 0, 0);
		add_request(KIND_POP, 0, 1);
		add_random(64, 150, 1'b0);

		// Largest page: a zero-byte block exactly at the end of the page
		start_phase(PG_BYTES_MAX, IDLE_RECV);
		add_request(KIND_POP, 0, 1);
		add_request(KIND_ALLOC_UNALIGNED, 65536 - 48, 0);
		add_request(KIND_ALLOC_UNALIGNED, 0, 0);
		add_request(KIND_ALLOC_ALIGNED, 0, 0);
		add_request(KIND_POP, 0, 1);
		add_random(65536, 250, 1'b0);

		// Out-of-range page size, clamped to the largest
		start_phase(17'h1FFFF, IDLE_BOTH);
		add_random(65536, 250, 1'b0);

		// Page no bigger than the header
		start_phase(17'(HDR), IDLE_NONE);
		add_request(KIND_POP, 0, 1);
		add_request(KIND_ALLOC_ALIGNED, 0, 0);
		add_request(KIND_ALLOC_UNALIGNED, 0, 0);
		add_request(KIND_ALLOC_ALIGNED, 1, 0);
		add_random(HDR, 50, 1'b0);

		start_phase(17'd8, IDLE_BOTH);
		add_request(KIND_POP, 0, 1);
		add_request(KIND_ALLOC_UNALIGNED, 0, 0);
		add_random(8, 50, 1'b0);

		start_phase(17'd2000, IDLE_SEND);
		add_random(2000, 200, 1'b0);

		// Teardown, then life on the oversized list alone
		start_phase(PG_BYTES_RESET, IDLE_RECV);
		add_request(KIND_POP, 0, 0);
		add_request(KIND_ALLOC_ALIGNED, 10, 0);
		add_request(KIND_PUSH, 0, 0);
		add_request(KIND_POP, 0, 1);
		add_request(KIND_ALLOC_UNALIGNED, 0, 0);
		add_request(KIND_POP, 0, 2);
		add_random(4096, 120, 1'b1);

		drain();
		$display("Covered %0d responses over %0d page-size phases:",
			grant_count, phase_count);
		$display("  %0d in page, %0d oversized, %0d none",
			placed_seen[PL_PAGE], placed_seen[PL_LARGE], placed_seen[PL_NONE]);
		$display("Status mix: ok %0d, out of space %0d, bad position %0d, stack full %0d",
			status_seen[ST_OK], status_seen[ST_NO_SPACE], status_seen[ST_BAD_POS],
			status_seen[ST_STACK_FULL]);
		if (mismatch_count == 0) begin
			$display("stack_arena_allocator_tb passed");
		end else begin
			$display("stack_arena_allocator_tb failed");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#(TIMEOUT_NS);
		$display("TIMEOUT with %0d responses outstanding", expected_grants.size());
		$display("stack_arena_allocator_tb failed");
		$finish;
	end

endmodule

[files.f]
hw/rtl/saa_pkg.sv
hw/rtl/saa_frame_mem.sv
hw/rtl/saa_core.sv
hw/rtl/stack_arena_allocator.sv
dv/stack_arena_allocator_tb.sv
